/* rtl/plist_pkg.sv */
// ----------------------------------------------------------------------------
// plist_pkg
// Shared constants and types for the positional list: capacity, field
// widths, operation and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int FILL_W   = $clog2(CAPACITY + 1);
    localparam int POS_W    = 4;
    localparam int CNT_W    = 4;
    localparam int WORD_W   = 32;
    // position and fill compared at one common width with headroom for fill+1
    localparam int CMP_W    = ((FILL_W > POS_W) ? FILL_W : POS_W) + 1;

    localparam int S_DATA_W = ((POS_W + WORD_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((WORD_W + CNT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        FN_READ   = 2'd0,
        FN_WRITE  = 2'd1,
        FN_INSERT = 2'd2,
        FN_DELETE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef struct packed {
        logic load;      // take the incoming word
        logic shift_up;  // take the entry of the cell below
        logic shift_dn;  // take the entry of the cell above
    } t_cell_ctl;

endpackage

/* rtl/plist_cell.sv */
// ----------------------------------------------------------------------------
// plist_cell
// One list slot. Holds a word and, per cycle, loads a new word, takes its
// lower neighbor (insert) or its upper neighbor (delete), or holds.
// ----------------------------------------------------------------------------
module plist_cell (
    input  logic                                i_clk,
    input  plist_pkg::t_cell_ctl                i_ctl,
    input  logic signed [plist_pkg::WORD_W-1:0] i_word,
    input  logic signed [plist_pkg::WORD_W-1:0] i_prev,
    input  logic signed [plist_pkg::WORD_W-1:0] i_next,
    output logic signed [plist_pkg::WORD_W-1:0] o_entry
);
    import plist_pkg::*;

    logic signed [WORD_W-1:0] r_entry;
    logic signed [WORD_W-1:0] n_entry;

    always_comb begin
        if (i_ctl.load) begin
            n_entry = i_word;
        end else if (i_ctl.shift_up) begin
            n_entry = i_prev;
        end else if (i_ctl.shift_dn) begin
            n_entry = i_next;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

/* rtl/positional_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Bounded list of signed 32-bit words with read, overwrite, insert and
// delete at a 1-based position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel  dir  tuser          tdata (low bit up)
//  s_*      in   func[1:0]      position[3:0], word_in[35:4]
//  m_*      out  status[1:0]    word_out[31:0], count[35:32]
//
//  One item per clock unless the output stalls: every cell shifts, loads or
//  holds in the same cycle, and the result is registered.
//  Input is taken whenever the result register is empty or being drained.
//  Reset (synchronous, active low) empties the list; cell contents are
//  left as they are and only positions below the fill count are visible.
// ----------------------------------------------------------------------------
module positional_list_insert_delete (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [1:0]                        i_s_tuser,  // func
    input  logic [plist_pkg::S_DATA_W-1:0]    i_s_tdata,  // position, word_in
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [1:0]                        o_m_tuser,  // status
    output logic [plist_pkg::M_DATA_W-1:0]    o_m_tdata   // word_out, count
);
    import plist_pkg::*;

    logic                     s_acc;
    t_func                    func;
    logic [POS_W-1:0]         pos;
    logic signed [WORD_W-1:0] word_in;
    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         fill_x;
    logic [CMP_W-1:0]         pos_m1;
    logic [IDX_W-1:0]         idx;
    logic                     in_range;
    logic                     ins_range;

    logic [FILL_W-1:0]        r_fill;
    logic [FILL_W-1:0]        n_fill;
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_status                  r_out_status;
    t_status                  n_status;
    logic signed [WORD_W-1:0] r_out_word;
    logic signed [WORD_W-1:0] n_word;
    logic [CNT_W-1:0]         r_out_count;

    logic do_write;
    logic do_insert;
    logic do_delete;

    t_cell_ctl                cell_ctl [CAPACITY];
    logic signed [WORD_W-1:0] entry    [CAPACITY];

    assign func    = t_func'(i_s_tuser);
    assign pos     = i_s_tdata[POS_W-1:0];
    assign word_in = i_s_tdata[POS_W+WORD_W-1:POS_W];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign pos_x     = CMP_W'(pos);
    assign fill_x    = CMP_W'(r_fill);
    assign pos_m1    = pos_x - CMP_W'(1);
    assign idx       = pos_m1[IDX_W-1:0];
    assign in_range  = (pos_x != '0) && (pos_x <= fill_x);
    assign ins_range = (pos_x != '0) && (pos_x <= fill_x + CMP_W'(1));

    always_comb begin
        n_status  = ST_OK;
        n_word    = '0;
        n_fill    = r_fill;
        do_write  = 1'b0;
        do_insert = 1'b0;
        do_delete = 1'b0;
        case (func)
            FN_READ: begin
                if (!in_range) begin
                    n_status = ST_BAD;
                end else begin
                    n_word = entry[idx];
                end
            end
            FN_WRITE: begin
                if (!in_range) begin
                    n_status = ST_BAD;
                end else begin
                    do_write = 1'b1;
                end
            end
            FN_INSERT: begin
                if (!ins_range) begin
                    n_status = ST_BAD;
                end else if (fill_x >= CMP_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    do_insert = 1'b1;
                    n_fill    = r_fill + FILL_W'(1);
                end
            end
            FN_DELETE: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else if (!in_range) begin
                    n_status = ST_BAD;
                end else begin
                    do_delete = 1'b1;
                    n_fill    = r_fill - FILL_W'(1);
                end
            end
            default: begin
                n_status = ST_BAD;
            end
        endcase
    end

    // per-cell control: cells above the position shift up on insert,
    // cells at or above it pull from above on delete
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [IDX_W-1:0] CellIdx = IDX_W'(g);

        assign cell_ctl[g].load     = s_acc && (do_write || do_insert) && (CellIdx == idx);
        assign cell_ctl[g].shift_up = s_acc && do_insert && (CellIdx > idx);
        assign cell_ctl[g].shift_dn = s_acc && do_delete && (CellIdx >= idx);

        plist_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_word  (word_in),
            .i_prev  ((g == 0) ? word_in : entry[(g == 0) ? 0 : g - 1]),
            .i_next  ((g == CAPACITY - 1) ? entry[g] : entry[(g == CAPACITY - 1) ? g : g + 1]),
            .o_entry (entry[g])
        );
    end

    always_comb begin
        if (s_acc) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (s_acc) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out_status <= n_status;
            r_out_word   <= n_word;
            r_out_count  <= CNT_W'(n_fill);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = M_DATA_W'({r_out_count, r_out_word});

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(CAPACITY))
        else $error("fill count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && do_insert) |=> (r_fill == $past(r_fill) + FILL_W'(1)))
        else $error("insert did not grow the list");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && do_delete) |=> (r_fill == $past(r_fill) - FILL_W'(1)))
        else $error("delete did not shrink the list");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_EMPTY) |-> (r_out_count == '0))
        else $error("empty status with nonzero count");

    a_word_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word != '0) |-> (r_out_status == ST_OK))
        else $error("word returned with error status");
`endif

endmodule

/* test/positional_list_insert_delete_tb.sv */
// ----------------------------------------------------------------------------
// positional_list_insert_delete_tb
// Self-checking bench for the positional list. A directed opener hits the
// empty, full and out-of-range cases and the word extremes. Random traffic
// follows: legal list operations with some noise, and a fill level that
// sweeps between empty and full. A shadow list predicts each reply, and
// replies are checked field by field in order. Random bursts and gaps on the
// input, random stalls and two long hold-offs on the output.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_tb;
    import plist_pkg::*;

    localparam int N_ITEMS    = 1950;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 80;

    typedef struct {
        t_func       fn;
        logic [3:0]  pos;
        logic [31:0] word;
    } t_op;

    typedef struct {
        t_status            status;
        logic signed [31:0] word;
        logic [3:0]         count;
    } t_reply;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [1:0]          i_s_tuser  = '0;  // func
    logic [S_DATA_W-1:0] i_s_tdata  = '0;  // position[3:0], word_in[35:4]
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [1:0]          o_m_tuser;        // status
    logic [M_DATA_W-1:0] o_m_tdata;        // word_out[31:0], count[35:32]

    positional_list_insert_delete dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    t_op    list_ops[$];
    t_reply pending_replies[$];
    int     gen_fill     = 0;   // fill level as the generator tracks it
    int     mismatches   = 0;
    int     replies_seen = 0;

    // shadow list
    logic [31:0] shadow_words [CAPACITY];
    int          shadow_fill = 0;

    function automatic t_reply list_apply(t_op op);
        t_reply r;
        int     p;
        int     i;
        p        = op.pos;
        r.status = ST_OK;
        r.word   = '0;
        case (op.fn)
            FN_READ: begin
                if (p < 1 || p > shadow_fill) r.status = ST_BAD;
                else r.word = shadow_words[p-1];
            end
            FN_WRITE: begin
                if (p < 1 || p > shadow_fill) r.status = ST_BAD;
                else shadow_words[p-1] = op.word;
            end
            FN_INSERT: begin
                if (p < 1 || p > shadow_fill + 1) begin
                    r.status = ST_BAD;
                end else if (shadow_fill >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = shadow_fill; i > p - 1; i--) shadow_words[i] = shadow_words[i-1];
                    shadow_words[p-1] = op.word;
                    shadow_fill++;
                end
            end
            default: begin
                if (shadow_fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (p < 1 || p > shadow_fill) begin
                    r.status = ST_BAD;
                end else begin
                    for (i = p - 1; i + 1 < shadow_fill; i++) shadow_words[i] = shadow_words[i+1];
                    shadow_fill--;
                end
            end
        endcase
        r.count = shadow_fill[3:0];
        return r;
    endfunction

    task automatic queue_op(t_func fn, int pos, logic [31:0] word);
        t_op op;
        op.fn   = fn;
        op.pos  = pos[3:0];
        op.word = word;
        list_ops.push_back(op);
        // keep the generator's view of the fill level in step
        if (fn == FN_INSERT && pos >= 1 && pos <= gen_fill + 1 && gen_fill < CAPACITY)
            gen_fill++;
        else if (fn == FN_DELETE && gen_fill > 0 && pos >= 1 && pos <= gen_fill)
            gen_fill--;
    endtask

    task automatic report_mismatch(string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // input side: bursts of random length, random gaps between them
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : feed_p
        t_op nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_s_tvalid <= 1'b0;
            end else if (list_ops.size() > 0) begin
                nxt = list_ops.pop_front();
                i_s_tuser  <= nxt.fn;
                i_s_tdata  <= {4'b0, nxt.word, nxt.pos};
                i_s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // output side: segments of steady, random or sparse ready, plus long holds
    int rx_cycles = 0;
    int hold_left = 0;
    int seg_left  = 0;
    int seg_mode  = 0;

    always @(posedge i_clk) begin : drain_p
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_cycles  <= 0;
            hold_left  <= 0;
            seg_left   <= 0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            if (rx_cycles == 500 || rx_cycles == 3000) begin
                hold_left  <= HOLD_LEN;
                i_m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left  <= hold_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left <= $urandom_range(1, 40);
                    seg_mode <= $urandom_range(0, 2);
                end else begin
                    seg_left <= seg_left - 1;
                end
                case (seg_mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= 1'($urandom_range(0, 1));
                    default: i_m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // predict on every accepted input beat, check every accepted output beat
    always @(posedge i_clk) begin : check_p
        t_op    seen;
        t_reply want;
        t_reply got;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                seen.fn   = t_func'(i_s_tuser);
                seen.pos  = i_s_tdata[3:0];
                seen.word = i_s_tdata[35:4];
                pending_replies.push_back(list_apply(seen));
            end
            if (o_m_tvalid && i_m_tready) begin
                got.status = t_status'(o_m_tuser);
                got.word   = o_m_tdata[31:0];
                got.count  = o_m_tdata[35:32];
                if (pending_replies.size() == 0) begin
                    report_mismatch($sformatf("reply %0d arrived with nothing expected",
                                              replies_seen));
                end else begin
                    want = pending_replies.pop_front();
                    if (got.status != want.status)
                        report_mismatch($sformatf("reply %0d status %s, expected %s",
                            replies_seen, got.status.name(), want.status.name()));
                    if (got.word !== want.word)
                        report_mismatch($sformatf("reply %0d word_out %0d, expected %0d",
                            replies_seen, got.word, want.word));
                    if (got.count !== want.count)
                        report_mismatch($sformatf("reply %0d count %0d, expected %0d",
                            replies_seen, got.count, want.count));
                end
                replies_seen++;
            end
        end
    end

    // watchdog: cycles with no beat on either side
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("positional_list_insert_delete test failed");
                $finish;
            end
        end
    end

    initial begin
        int          k;
        int          r;
        int          q;
        int          w_ins;
        int          w_del;
        int          hi;
        int          pos;
        bit          grow;
        t_func       fn;
        logic [31:0] word;

        // directed opener
        queue_op(FN_READ,   1, 32'h1234_5678);   // read on empty list
        queue_op(FN_DELETE, 0, 32'h0);           // empty check wins over bad position
        queue_op(FN_DELETE, 8, 32'h0);
        queue_op(FN_INSERT, 0, 32'h0);           // position zero
        queue_op(FN_INSERT, 2, 32'h5);           // beyond fill+1
        queue_op(FN_WRITE,  1, 32'h5);
        queue_op(FN_INSERT, 1, 32'h8000_0000);
        queue_op(FN_INSERT, 1, 32'h7FFF_FFFF);   // at the front
        queue_op(FN_INSERT, 3, 32'hFFFF_FFFF);   // at the tail
        queue_op(FN_INSERT, 2, 32'h0);           // in the middle
        for (k = 0; k < 4; k++) queue_op(FN_INSERT, gen_fill + 1, $urandom);
        queue_op(FN_INSERT, 8, 32'h1);           // full list
        queue_op(FN_INSERT, 1, 32'h2);
        queue_op(FN_READ,   8, 32'h0);
        queue_op(FN_READ,   1, 32'hFFFF_FFFF);   // word_in ignored on read
        queue_op(FN_WRITE,  8, 32'h8000_0000);
        queue_op(FN_READ,   8, 32'h0);
        queue_op(FN_READ,   0, 32'h0);
        queue_op(FN_DELETE, 0, 32'hFFFF_FFFF);
        queue_op(FN_DELETE, 1, 32'h0);
        queue_op(FN_DELETE, 7, 32'h0);           // last entry
        queue_op(FN_READ,   7, 32'h0);           // just past the tail

        // random traffic: fill level drifts up and down between the bounds
        grow = 1'b1;
        while (list_ops.size() < N_ITEMS) begin
            case ($urandom_range(0, 7))
                0: begin
                    case ($urandom_range(0, 3))
                        0:       word = 32'h8000_0000;
                        1:       word = 32'h7FFF_FFFF;
                        2:       word = 32'h0;
                        default: word = 32'hFFFF_FFFF;
                    endcase
                end
                default: word = $urandom;
            endcase
            if (gen_fill == CAPACITY || (gen_fill == 0 && !grow) || $urandom_range(0, 59) == 0)
                grow = (gen_fill == 0) ? 1'b1 : (gen_fill == CAPACITY) ? 1'b0 : !grow;
            r = $urandom_range(0, 99);
            if (r < 12) begin
                fn  = t_func'($urandom_range(0, 3));
                pos = $urandom_range(0, 8);
            end else begin
                w_ins = grow ? 40 : 15;
                w_del = grow ? 15 : 40;
                q = $urandom_range(0, 99);
                if (q < w_ins) fn = FN_INSERT;
                else if (q < w_ins + w_del) fn = FN_DELETE;
                else if (q < w_ins + w_del + (100 - w_ins - w_del) / 2) fn = FN_READ;
                else fn = FN_WRITE;
                if (fn == FN_INSERT) begin
                    hi  = (gen_fill + 1 > CAPACITY) ? CAPACITY : gen_fill + 1;
                    pos = $urandom_range(1, hi);
                end else if (gen_fill == 0) begin
                    pos = $urandom_range(0, 8);
                end else begin
                    pos = $urandom_range(1, gen_fill);
                end
            end
            queue_op(fn, pos, word);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every queued op yields exactly one reply; a lost one trips the watchdog
        while (replies_seen < N_ITEMS)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatches == 0 && pending_replies.size() == 0) begin
            $display("positional_list_insert_delete test passed");
        end else begin
            $display("positional_list_insert_delete test failed");
        end
        $finish;
    end

endmodule
